/* hdl/leb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line edit buffer package
// Command codes, sequencer states, transfer structs and character limits
// used by the line edit buffer unit.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int CAPACITY_DEF = 32;    // default text capacity in characters
    localparam int CHAR_W       = 8;     // width of a character on the ports
    localparam int STORE_W      = 7;     // width of a stored character

    localparam logic [CHAR_W-1:0] CHAR_LO = 8'h20;   // lowest printable byte
    localparam logic [CHAR_W-1:0] CHAR_HI = 8'h7E;   // highest printable byte

    typedef enum logic [2:0] {
        CMD_HOME  = 3'd0,
        CMD_END   = 3'd1,
        CMD_LEFT  = 3'd2,
        CMD_RIGHT = 3'd3,
        CMD_TYPE  = 3'd4,
        CMD_ERASE = 3'd5,
        CMD_PRINT = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_KEY,
        ST_ERA,
        ST_PRT
    } t_state;

    typedef struct packed {
        t_cmd              command;
        logic [CHAR_W-1:0] key_char;
        logic [CHAR_W-1:0] separator_char;
    } t_in;

    typedef struct packed {
        logic              ok;
        logic              char_valid;
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } t_out;

endpackage

/* hdl/line_edit_buffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line edit buffer
// One-line text buffer with a cursor: cursor moves, insert, erase and print,
// run by a small sequencer around one text RAM and one index counter.
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  command   i_start, o_busy, i_in       taken when i_start & !o_busy
//  result    o_valid, o_out              at most one result per cycle, no stall
//
//  Cursor moves, insert at the end and erase at the end: result registered,
//  on the next cycle. Insert inside the text shifts the tail up from the end,
//  then writes the key. Erase inside the text shifts the tail down from the
//  cursor. Print: results back to back, paced by the single RAM read port and
//  the index counter. Reset leaves an empty text with the cursor at zero; the
//  RAM itself is not cleared.
// ----------------------------------------------------------------------------
module line_edit_buffer_unit #(
    parameter int CAPACITY = leb_pkg::CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  leb_pkg::t_in i_in,
    output logic         o_valid,
    output leb_pkg::t_out o_out
);

    import leb_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(CAPACITY + 2);

    t_state              r_state, n_state;
    logic [LW-1:0]       r_len, n_len;
    logic [LW-1:0]       r_cur, n_cur;
    logic [AW-1:0]       r_idx, n_idx;
    logic [KW-1:0]       r_k, n_k;
    logic [KW-1:0]       r_num, n_num;
    logic [CHAR_W-1:0]   r_sep, n_sep;
    logic [STORE_W-1:0]  r_key, n_key;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [STORE_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [STORE_W-1:0]  ram_rdata;

    logic                key_ok;
    logic [KW-1:0]       k_next;
    logic                sep_on;

    leb_ram #(
        .WIDTH (STORE_W),
        .DEPTH (CAPACITY),
        .ADDR_W(AW)
    ) u_text (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_k   <= n_k;
        r_num <= n_num;
        r_sep <= n_sep;
        r_key <= n_key;
        r_out <= n_out;
    end

    assign key_ok = (i_in.key_char >= CHAR_LO) && (i_in.key_char <= CHAR_HI);
    assign k_next = r_k + 1'b1;
    assign sep_on = (r_sep != '0);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_cur       = r_cur;
        n_idx       = r_idx;
        n_k         = r_k;
        n_num       = r_num;
        n_sep       = r_sep;
        n_key       = r_key;
        n_out_valid = 1'b0;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = ram_rdata;
        ram_raddr   = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    // default single result: ok, no character, last
                    n_out_valid = 1'b1;
                    n_out       = '{ok: 1'b1, char_valid: 1'b0, out_char: '0, last: 1'b1};
                    case (i_in.command)
                        CMD_HOME: begin
                            n_cur = '0;
                        end
                        CMD_END: begin
                            n_cur = r_len;
                        end
                        CMD_LEFT: begin
                            if (r_cur != '0) begin
                                n_cur = r_cur - 1'b1;
                            end
                        end
                        CMD_RIGHT: begin
                            if (r_cur < r_len) begin
                                n_cur = r_cur + 1'b1;
                            end
                        end
                        CMD_TYPE: begin
                            n_key = i_in.key_char[STORE_W-1:0];
                            if ((r_len >= LW'(CAPACITY)) || !key_ok) begin
                                n_out.ok = 1'b0;
                            end else if (r_cur == r_len) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_cur);
                                ram_wdata = i_in.key_char[STORE_W-1:0];
                                n_len     = r_len + 1'b1;
                                n_cur     = r_cur + 1'b1;
                            end else begin
                                // shift the tail up, starting from the end
                                n_out_valid = 1'b0;
                                ram_raddr   = AW'(r_len - 1'b1);
                                n_idx       = AW'(r_len - 1'b1);
                                n_state     = ST_INS;
                            end
                        end
                        CMD_ERASE: begin
                            if (r_cur == '0) begin
                                n_out.ok = 1'b0;
                            end else if (r_cur == r_len) begin
                                n_len = r_len - 1'b1;
                                n_cur = r_cur - 1'b1;
                            end else begin
                                // shift the tail down, starting at the cursor
                                n_out_valid = 1'b0;
                                ram_raddr   = AW'(r_cur);
                                n_idx       = AW'(r_cur);
                                n_state     = ST_ERA;
                            end
                        end
                        CMD_PRINT: begin
                            n_sep = i_in.separator_char;
                            n_num = KW'(r_len) + KW'(i_in.separator_char != '0);
                            n_k   = '0;
                            if ((r_len != '0) || (i_in.separator_char != '0)) begin
                                // read entry zero first; the separator goes first when the cursor is at zero
                                n_out_valid = 1'b0;
                                ram_raddr   = '0;
                                n_state     = ST_PRT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx + 1'b1;
                ram_wdata = ram_rdata;
                if (LW'(r_idx) == r_cur) begin
                    n_state = ST_KEY;
                end else begin
                    ram_raddr = r_idx - 1'b1;
                    n_idx     = r_idx - 1'b1;
                end
            end
            ST_KEY: begin
                ram_we      = 1'b1;
                ram_waddr   = AW'(r_cur);
                ram_wdata   = r_key;
                n_len       = r_len + 1'b1;
                n_cur       = r_cur + 1'b1;
                n_out_valid = 1'b1;
                n_out       = '{ok: 1'b1, char_valid: 1'b0, out_char: '0, last: 1'b1};
                n_state     = ST_IDLE;
            end
            ST_ERA: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx - 1'b1;
                ram_wdata = ram_rdata;
                if (LW'(r_idx) == (r_len - 1'b1)) begin
                    n_len       = r_len - 1'b1;
                    n_cur       = r_cur - 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '{ok: 1'b1, char_valid: 1'b0, out_char: '0, last: 1'b1};
                    n_state     = ST_IDLE;
                end else begin
                    ram_raddr = r_idx + 1'b1;
                    n_idx     = r_idx + 1'b1;
                end
            end
            ST_PRT: begin
                n_out_valid      = 1'b1;
                n_out.ok         = 1'b1;
                n_out.char_valid = 1'b1;
                n_out.last       = (r_k == (r_num - 1'b1));
                if (sep_on && (r_k == KW'(r_cur))) begin
                    n_out.out_char = r_sep;
                end else begin
                    n_out.out_char = {1'b0, ram_rdata};
                end
                // fetch for the next result; past the cursor mark, text lags by one
                if (sep_on && (k_next > KW'(r_cur))) begin
                    ram_raddr = AW'(k_next - 1'b1);
                end else begin
                    ram_raddr = AW'(k_next);
                end
                n_k = k_next;
                if (r_k == (r_num - 1'b1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_len)
        else $error("cursor beyond end of text");

    a_length_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("text length beyond capacity");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.last) |=> o_valid)
        else $error("result burst broken before last transfer");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.char_valid) |-> o_out.last)
        else $error("result without character is not the last transfer");

endmodule

/* hdl/leb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module leb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
